### sv/wtdg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtdg_pkg
// back-end state type and reset limit of the windowed time difference generator
// ----------------------------------------------------------------------------
package wtdg_pkg;

	typedef enum logic [0:0] {
		BK_IDLE,
		BK_WALK
	} back_state_t;

	localparam longint unsigned MAX_DIFF_RESET = 64'd1000000;

endpackage
`default_nettype wire

### sv/wtdg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtdg_if
// valid/ready channels for event timestamps and time difference results
// ----------------------------------------------------------------------------
interface wtdg_event_if #(
	parameter int TIME_WIDTH = 48
);
	logic                  valid;
	logic                  ready;
	logic [TIME_WIDTH-1:0] event_time;

	modport source (output valid, output event_time, input ready);
	modport sink   (input valid, input event_time, output ready);
endinterface

interface wtdg_result_if #(
	parameter int TIME_WIDTH = 48
);
	logic                  valid;
	logic                  ready;
	logic [TIME_WIDTH-1:0] time_difference;
	logic                  out_of_order;
	logic                  last;

	modport source (output valid, output time_difference, output out_of_order, output last,
		input ready);
	modport sink   (input valid, input time_difference, input out_of_order, input last,
		output ready);
endinterface
`default_nettype wire

### sv/windowed_time_difference_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_time_difference_generator
// time differences between each new event and the recent event history
// ----------------------------------------------------------------------------
// An event whose timestamp is not below the newest stored one is loaded into
// the back end, which then walks n stored timestamps, n being the number that
// the walk reads (at most WINDOW-1 and none when the history is empty): one
// history read per cycle from the single read port of the history ring while
// the result output does not stall, a registered read of the last entry, and
// then a store of the new timestamp. One result transaction leaves per
// cycle while differences stay below max_difference; an early stop cuts the
// walk short and a stalled result output stalls the walk. An out-of-order
// event gives one flagged transaction. A two-entry queue lets the front end
// take events while the back end walks. The history needs no clearing after
// reset.
// ----------------------------------------------------------------------------
module windowed_time_difference_generator #(
	parameter int WINDOW     = 64,
	parameter int TIME_WIDTH = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TIME_WIDTH-1:0] cfg_wdata,
	wtdg_event_if.sink            event_ch,
	wtdg_result_if.source         result_ch
);

	localparam int DEPTH = WINDOW - 1;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int QW    = TIME_WIDTH + 1 + CW + PW;

	logic          push_valid;
	logic          push_ready;
	logic [QW-1:0] push_data;
	logic          pop_valid;
	logic          pop_ready;
	logic [QW-1:0] pop_data;

	wtdg_front #(
		.WINDOW     (WINDOW),
		.TIME_WIDTH (TIME_WIDTH),
		.QW         (QW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_ch.valid),
		.event_ready (event_ch.ready),
		.event_time  (event_ch.event_time),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	wtdg_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	wtdg_back #(
		.WINDOW     (WINDOW),
		.TIME_WIDTH (TIME_WIDTH),
		.QW         (QW)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.q_valid             (pop_valid),
		.q_ready             (pop_ready),
		.q_data              (pop_data),
		.res_valid           (result_ch.valid),
		.res_ready           (result_ch.ready),
		.res_time_difference (result_ch.time_difference),
		.res_out_of_order    (result_ch.out_of_order),
		.res_last            (result_ch.last)
	);

endmodule
`default_nettype wire

### sv/wtdg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtdg_fifo
// two-entry queue between the classifying front end and the walking back end
// ----------------------------------------------------------------------------
module wtdg_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

### sv/wtdg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtdg_front
// accepts timestamps, flags out-of-order ones and tags each with its history
// snapshot (entry count and ring slot) for the back end
// ----------------------------------------------------------------------------
module wtdg_front #(
	parameter int WINDOW     = 64,
	parameter int TIME_WIDTH = 48,
	parameter int QW         = 61
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  event_valid,
	output logic                  event_ready,
	input  logic [TIME_WIDTH-1:0] event_time,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [QW-1:0]         push_data
);

	localparam int DEPTH = WINDOW - 1;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [TIME_WIDTH-1:0] newest_q;
	logic [CW-1:0]         count_q;
	logic [PW-1:0]         wp_q;
	logic                  accept;
	logic                  ooo;

	assign event_ready = push_ready;
	assign push_valid  = event_valid;
	assign accept      = event_valid && push_ready;
	assign ooo         = (count_q != '0) && (event_time < newest_q);
	assign push_data   = {event_time, ooo, count_q, wp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wp_q    <= '0;
		end else if (accept && !ooo) begin
			if (wp_q == PW'(DEPTH - 1)) wp_q <= '0;
			else wp_q <= wp_q + PW'(1);
			if (count_q != CW'(DEPTH)) count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !ooo) newest_q <= event_time;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("history count above depth");

	a_ptr_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q < CW'(DEPTH)) |-> (CW'(wp_q) == count_q))
		else $error("write slot out of step with count");

	a_newest_update: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ooo) |=> (newest_q == $past(event_time)))
		else $error("newest timestamp not recorded");

endmodule
`default_nettype wire

### sv/wtdg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtdg_back
// walks the history ring newest to oldest and emits differences below the
// limit, stores the new timestamp after the walk, flags out-of-order events
// ----------------------------------------------------------------------------
module wtdg_back #(
	parameter int WINDOW     = 64,
	parameter int TIME_WIDTH = 48,
	parameter int QW         = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TIME_WIDTH-1:0] cfg_wdata,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic [QW-1:0]         q_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [TIME_WIDTH-1:0] res_time_difference,
	output logic                  res_out_of_order,
	output logic                  res_last
);

	localparam int DEPTH = WINDOW - 1;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [TIME_WIDTH-1:0] MAX_RESET = TIME_WIDTH'(wtdg_pkg::MAX_DIFF_RESET);

	// queue word: {time, out_of_order, count, slot}
	logic [TIME_WIDTH-1:0] q_time;
	logic                  q_ooo;
	logic [CW-1:0]         q_cnt;
	logic [PW-1:0]         q_wp;

	assign q_wp   = q_data[PW-1:0];
	assign q_cnt  = q_data[PW+CW-1:PW];
	assign q_ooo  = q_data[PW+CW];
	assign q_time = q_data[PW+CW+TIME_WIDTH:PW+CW+1];

	wtdg_pkg::back_state_t state_q, state_d;

	logic [TIME_WIDTH-1:0] hist_mem [DEPTH];
	logic [TIME_WIDTH-1:0] max_q;
	logic [TIME_WIDTH-1:0] t_q, t_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [CW-1:0]         k_q, k_d;
	logic [PW-1:0]         rp_q, rp_d;
	logic [PW-1:0]         wp_q, wp_d;
	logic                  rd_v_s1, rd_v_d;
	logic [TIME_WIDTH-1:0] rd_data_s1;
	logic                  pend_v_q, pend_v_d;
	logic [TIME_WIDTH-1:0] pend_diff_q, pend_diff_d;
	logic                  out_valid_q, out_valid_d;
	logic [TIME_WIDTH-1:0] out_diff_q;
	logic                  out_ooo_q;
	logic                  out_last_q;

	logic                  en;
	logic [TIME_WIDTH-1:0] diff1;
	logic                  pass1;
	logic                  emit;
	logic [TIME_WIDTH-1:0] emit_diff;
	logic                  emit_ooo;
	logic                  emit_last;
	logic                  issue;
	logic                  mem_we;
	logic                  finish;

	assign en    = !out_valid_q || res_ready;
	assign diff1 = t_q - rd_data_s1;
	assign pass1 = diff1 < max_q;

	always_comb begin
		state_d     = state_q;
		t_d         = t_q;
		cnt_d       = cnt_q;
		k_d         = k_q;
		rp_d        = rp_q;
		wp_d        = wp_q;
		rd_v_d      = rd_v_s1;
		pend_v_d    = pend_v_q;
		pend_diff_d = pend_diff_q;
		emit        = 1'b0;
		emit_diff   = pend_diff_q;
		emit_ooo    = 1'b0;
		emit_last   = 1'b0;
		issue       = 1'b0;
		mem_we      = 1'b0;
		finish      = 1'b0;
		q_ready     = 1'b0;
		case (state_q)
			wtdg_pkg::BK_IDLE: begin
				if (en && q_valid) begin
					q_ready = 1'b1;
					if (q_ooo) begin
						emit      = 1'b1;
						emit_diff = '0;
						emit_ooo  = 1'b1;
						emit_last = 1'b1;
					end else begin
						state_d  = wtdg_pkg::BK_WALK;
						t_d      = q_time;
						cnt_d    = q_cnt;
						k_d      = '0;
						wp_d     = q_wp;
						rp_d     = (q_wp == '0) ? PW'(DEPTH - 1) : q_wp - PW'(1);
						rd_v_d   = 1'b0;
						pend_v_d = 1'b0;
					end
				end
			end
			wtdg_pkg::BK_WALK: begin
				if (en) begin
					if (rd_v_s1) begin
						if (pass1) begin
							emit        = pend_v_q;
							pend_v_d    = 1'b1;
							pend_diff_d = diff1;
						end else begin
							emit      = pend_v_q;
							emit_last = 1'b1;
							finish    = 1'b1;
						end
					end else if (k_q == cnt_q) begin
						emit      = pend_v_q;
						emit_last = 1'b1;
						finish    = 1'b1;
					end
					if (finish) begin
						mem_we   = 1'b1;
						pend_v_d = 1'b0;
						rd_v_d   = 1'b0;
						state_d  = wtdg_pkg::BK_IDLE;
					end else if (k_q != cnt_q) begin
						issue  = 1'b1;
						k_d    = k_q + CW'(1);
						rp_d   = (rp_q == '0) ? PW'(DEPTH - 1) : rp_q - PW'(1);
						rd_v_d = 1'b1;
					end else begin
						rd_v_d = 1'b0;
					end
				end
			end
			default: begin
				state_d = wtdg_pkg::BK_IDLE;
			end
		endcase
		if (emit) out_valid_d = 1'b1;
		else if (res_ready) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wtdg_pkg::BK_IDLE;
			rd_v_s1     <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			max_q       <= MAX_RESET;
		end else begin
			state_q     <= state_d;
			rd_v_s1     <= rd_v_d;
			pend_v_q    <= pend_v_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		t_q         <= t_d;
		cnt_q       <= cnt_d;
		k_q         <= k_d;
		rp_q        <= rp_d;
		wp_q        <= wp_d;
		pend_diff_q <= pend_diff_d;
		if (emit) begin
			out_diff_q <= emit_diff;
			out_ooo_q  <= emit_ooo;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[wp_q] <= t_q;
		if (issue) rd_data_s1 <= hist_mem[rp_q];
	end

	assign res_valid           = out_valid_q;
	assign res_time_difference = out_diff_q;
	assign res_out_of_order    = out_ooo_q;
	assign res_last            = out_last_q;

	a_ooo_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ooo_q) |-> (out_last_q && (out_diff_q == '0)))
		else $error("out-of-order transaction malformed");

	a_no_read_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && issue))
		else $error("history read during store");

	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wtdg_pkg::BK_WALK) |-> (k_q <= cnt_q))
		else $error("walk index past entry count");

	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == wtdg_pkg::BK_WALK))
		else $error("pending result outside walk");

endmodule
`default_nettype wire
